// ----- hdl/gf16_region_mul_add_core_defines.svh -----
// ----------------------------------------------------------------------------
// gf16_region_mul_add_core_defines
// assertion macros shared by the gf16 region multiply-add core
// ----------------------------------------------------------------------------
`ifndef GF16_REGION_MUL_ADD_CORE_DEFINES_SVH
`define GF16_REGION_MUL_ADD_CORE_DEFINES_SVH

// checked only while out of reset
`define GF16RMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gf16rma assertion failed");

// checked through reset as well
`define GF16RMA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gf16rma reset assertion failed");

`endif

// ----- hdl/gf16rma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf16rma_pkg
// types, register codes and the gf(2^16) nibble step for the region core
// ----------------------------------------------------------------------------
package gf16rma_pkg;

  localparam int WordW     = 16;
  localparam int PolyW     = 17;
  localparam int NibW      = 4;
  localparam int NumStages = WordW / NibW;
  localparam int NumLanes  = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = PolyW;
  localparam int CountW    = 2;

  localparam logic [PolyW-1:0]  PolyReset  = 17'h1100b;
  localparam logic [CountW-1:0] CountReset = 2'd1;
  localparam logic [CountW-1:0] CountThree = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    RegPolynomial  = 3'd0,
    RegCoefA       = 3'd1,
    RegCoefB       = 3'd2,
    RegCoefC       = 3'd3,
    RegSourceCount = 3'd4,
    RegAccumulate  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] src_a;
    logic [WordW-1:0] src_b;
    logic [WordW-1:0] src_c;
    logic [WordW-1:0] dst_old;
    logic             last_word;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] dst_new;
    logic             last;
  } result_t;

  // four msb-first shift-and-reduce steps of a gf(2^16) multiply
  function automatic logic [WordW-1:0] gf_nibble(
    input logic [WordW-1:0] acc_in,
    input logic [WordW-1:0] x,
    input logic [NibW-1:0]  ybits,
    input logic [WordW-1:0] taps
  );
    logic [WordW-1:0] acc;
    logic             top;
    acc = acc_in;
    for (int i = NibW - 1; i >= 0; i--) begin
      top = acc[WordW-1];
      acc = {acc[WordW-2:0], 1'b0};
      if (top) begin
        acc = acc ^ taps;
      end
      if (ybits[i]) begin
        acc = acc ^ x;
      end
    end
    return acc;
  endfunction

endpackage

// ----- hdl/gf16_region_mul_add_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf16_region_mul_add_core
// streaming gf(2^16) multiply / multiply-accumulate over three source words
// ----------------------------------------------------------------------------
// channel  | signals                          | role
// item     | item_valid item_ready item       | sources, old dst word, last flag
// result   | result_valid result_ready result | new dst word, last flag
// config   | cfg_we cfg_index cfg_data        | register write, no wait
//
// one word per cycle while the result side is not stalled; four register stages,
// each doing one coefficient nibble of all three lane multipliers, the first
// loaded at the accepting edge and the result register last. the last stage
// also folds the lanes and the old destination word together.
// a stall holds every filled stage; empty stages still fill (bubbles collapse).
// synchronous reset clears valid bits and loads register defaults.
`include "gf16_region_mul_add_core_defines.svh"

module gf16_region_mul_add_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    item_valid,
  output logic                                    item_ready,
  input  gf16rma_pkg::item_t                      item,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output gf16rma_pkg::result_t                    result,
  input  logic                                    cfg_we,
  input  logic [gf16rma_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [gf16rma_pkg::CfgDataW-1:0]        cfg_data
);

  localparam int WordW  = gf16rma_pkg::WordW;
  localparam int NibW   = gf16rma_pkg::NibW;
  localparam int NumStg = gf16rma_pkg::NumStages;
  localparam int NumLn  = gf16rma_pkg::NumLanes;
  localparam int NumReg = NumStg - 1;

  // configuration registers
  logic [gf16rma_pkg::PolyW-1:0]  polynomial;
  logic [WordW-1:0]               coef_a;
  logic [WordW-1:0]               coef_b;
  logic [WordW-1:0]               coef_c;
  logic [gf16rma_pkg::CountW-1:0] source_count;
  logic                           accumulate;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial   <= gf16rma_pkg::PolyReset;
      coef_a       <= '0;
      coef_b       <= '0;
      coef_c       <= '0;
      source_count <= gf16rma_pkg::CountReset;
      accumulate   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gf16rma_pkg::RegPolynomial:  polynomial   <= cfg_data;
        gf16rma_pkg::RegCoefA:       coef_a       <= cfg_data[WordW-1:0];
        gf16rma_pkg::RegCoefB:       coef_b       <= cfg_data[WordW-1:0];
        gf16rma_pkg::RegCoefC:       coef_c       <= cfg_data[WordW-1:0];
        gf16rma_pkg::RegSourceCount: source_count <= cfg_data[gf16rma_pkg::CountW-1:0];
        gf16rma_pkg::RegAccumulate:  accumulate   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [WordW-1:0] taps;
  logic [WordW-1:0] coef [NumLn];
  assign taps    = polynomial[WordW-1:0];
  assign coef[0] = coef_a;
  assign coef[1] = coef_b;
  assign coef[2] = coef_c;

  // pipeline registers between the nibble stages
  logic             stage_vld  [NumReg];
  logic [WordW-1:0] stage_acc  [NumReg][NumLn];
  logic [WordW-1:0] stage_src  [NumReg][NumLn];
  logic [WordW-1:0] stage_dst  [NumReg];
  logic             stage_last [NumReg];

  // load enables, one per register stage, the last one is the result register
  logic             ld [NumStg];
  logic [WordW-1:0] acc_in  [NumStg][NumLn];
  logic [WordW-1:0] src_in  [NumStg][NumLn];
  logic [WordW-1:0] acc_next [NumStg][NumLn];
  logic [WordW-1:0] sum_next;

  always_comb begin
    ld[NumStg-1] = !result_valid || result_ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      ld[k] = !stage_vld[k] || ld[k+1];
    end
  end

  assign item_ready = ld[0];

  always_comb begin
    src_in[0][0] = item.src_a;
    src_in[0][1] = item.src_b;
    src_in[0][2] = item.src_c;
    for (int l = 0; l < NumLn; l++) begin
      acc_in[0][l] = '0;
    end
    for (int k = 1; k < NumStg; k++) begin
      for (int l = 0; l < NumLn; l++) begin
        acc_in[k][l] = stage_acc[k-1][l];
        src_in[k][l] = stage_src[k-1][l];
      end
    end
    for (int k = 0; k < NumStg; k++) begin
      for (int l = 0; l < NumLn; l++) begin
        acc_next[k][l] = gf16rma_pkg::gf_nibble(acc_in[k][l], src_in[k][l],
                           coef[l][WordW-1-k*NibW -: NibW], taps);
      end
    end
  end

  // fold the lanes: count zero acts as one
  always_comb begin
    sum_next = acc_next[NumStg-1][0];
    if (source_count[1]) begin
      sum_next = sum_next ^ acc_next[NumStg-1][1];
    end
    if (source_count == gf16rma_pkg::CountThree) begin
      sum_next = sum_next ^ acc_next[NumStg-1][2];
    end
    if (accumulate) begin
      sum_next = sum_next ^ stage_dst[NumReg-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumReg; k++) begin
        stage_vld[k] <= 1'b0;
      end
      result_valid <= 1'b0;
    end else begin
      if (ld[0]) begin
        stage_vld[0] <= item_valid;
      end
      for (int k = 1; k < NumReg; k++) begin
        if (ld[k]) begin
          stage_vld[k] <= stage_vld[k-1];
        end
      end
      if (ld[NumStg-1]) begin
        result_valid <= stage_vld[NumReg-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      stage_dst[0]  <= item.dst_old;
      stage_last[0] <= item.last_word;
      for (int l = 0; l < NumLn; l++) begin
        stage_acc[0][l] <= acc_next[0][l];
        stage_src[0][l] <= src_in[0][l];
      end
    end
    for (int k = 1; k < NumReg; k++) begin
      if (ld[k]) begin
        stage_dst[k]  <= stage_dst[k-1];
        stage_last[k] <= stage_last[k-1];
        for (int l = 0; l < NumLn; l++) begin
          stage_acc[k][l] <= acc_next[k][l];
          stage_src[k][l] <= src_in[k][l];
        end
      end
    end
    if (ld[NumStg-1]) begin
      result.dst_new <= sum_next;
      result.last    <= stage_last[NumReg-1];
    end
  end

  logic pipe_full;
  always_comb begin
    pipe_full = result_valid;
    for (int k = 0; k < NumReg; k++) begin
      pipe_full = pipe_full && stage_vld[k];
    end
  end

  // an empty result register means the whole chain can move
  `GF16RMA_ASSERT(a_ready_when_out_empty, !result_valid |-> item_ready)
  // a full chain behind a stalled result takes nothing in
  `GF16RMA_ASSERT(a_full_stall_blocks, (pipe_full && !result_ready) |-> !item_ready)
  // reset leaves no result pending
  `GF16RMA_ASSERT_RST(a_reset_empties, rst |=> !result_valid)

endmodule

// ----- sim/gf16_region_mul_add_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf16_region_mul_add_checker
// watches the register port and both beat channels of the gf(2^16) region
// core, keeps its own register copy, predicts each destination word from the
// accepted item beat and compares it with the next result beat in order
// ----------------------------------------------------------------------------
module gf16_region_mul_add_checker
  import gf16rma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  item_t               item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  result_t             result,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  errors,
  output int                  pending
);

  localparam int ProdW = 2 * WordW - 1;

  logic [PolyW-1:0]  poly_q;
  logic [WordW-1:0]  coef_a_q;
  logic [WordW-1:0]  coef_b_q;
  logic [WordW-1:0]  coef_c_q;
  logic [CountW-1:0] count_q;
  logic              accum_q;

  result_t dst_words_due[$];

  // carry-less product, then fold the high bits back with x^16 + taps
  function automatic logic [WordW-1:0] gf16_product(
    input logic [WordW-1:0] x,
    input logic [WordW-1:0] y,
    input logic [WordW-1:0] taps
  );
    logic [ProdW-1:0] prod;
    prod = '0;
    for (int i = 0; i < WordW; i++) begin
      if (y[i]) begin
        prod = prod ^ (ProdW'(x) << i);
      end
    end
    for (int i = ProdW - 1; i >= WordW; i--) begin
      if (prod[i]) begin
        prod = prod ^ (ProdW'({1'b1, taps}) << (i - WordW));
      end
    end
    return prod[WordW-1:0];
  endfunction

  function automatic result_t region_mac(input item_t w);
    result_t          r;
    logic [WordW-1:0] taps;
    logic [WordW-1:0] sum;
    // bit 16 of the polynomial is implied, only the low taps matter
    taps = poly_q[WordW-1:0];
    sum  = gf16_product(w.src_a, coef_a_q, taps);
    // a count of zero behaves like one
    if (count_q >= 2) begin
      sum = sum ^ gf16_product(w.src_b, coef_b_q, taps);
    end
    if (count_q >= 3) begin
      sum = sum ^ gf16_product(w.src_c, coef_c_q, taps);
    end
    if (accum_q) begin
      sum = sum ^ w.dst_old;
    end
    r.dst_new = sum;
    r.last    = w.last_word;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      poly_q   <= PolyReset;
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      count_q  <= CountReset;
      accum_q  <= 1'b0;
      dst_words_due.delete();
      errors   = 0;
      pending  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          RegPolynomial:  poly_q   <= cfg_data[PolyW-1:0];
          RegCoefA:       coef_a_q <= cfg_data[WordW-1:0];
          RegCoefB:       coef_b_q <= cfg_data[WordW-1:0];
          RegCoefC:       coef_c_q <= cfg_data[WordW-1:0];
          RegSourceCount: count_q  <= cfg_data[CountW-1:0];
          RegAccumulate:  accum_q  <= cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        dst_words_due.push_back(region_mac(item));
      end
      if (result_valid && result_ready) begin
        if (dst_words_due.size() == 0) begin
          $error("result beat with no word due: dst_new %h last %b",
                 result.dst_new, result.last);
          errors++;
        end else begin
          want = dst_words_due.pop_front();
          if (result.dst_new !== want.dst_new) begin
            $error("dst_new: expected %h, actual %h", want.dst_new, result.dst_new);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, result.last);
            errors++;
          end
        end
      end
      pending <= dst_words_due.size();
    end
  end

endmodule

// ----- sim/gf16_region_mul_add_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf16_region_mul_add_core_tb
// drives register setups and region word streams into the gf(2^16) core with
// bursty item beats and a stalling result side; the checker does the scoring
// ----------------------------------------------------------------------------
module gf16_region_mul_add_core_tb;
  import gf16rma_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
  localparam int SettleCycles = 8;
  localparam int IdleLimit    = 2000;
  localparam int NumPhases    = 12;

  typedef enum int {ReadyAlways, ReadyRandom, ReadyStall} ready_mode_e;

  logic                clk;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  item_t               item         = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                cfg_we       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = RegPolynomial;
  logic [CfgDataW-1:0] cfg_data     = '0;

  int          check_errors;
  int          words_due;
  int          burst_left;
  int          idle_cycles;
  ready_mode_e ready_mode;
  int          ready_mode_left;
  int          stall_left;

  gf16_region_mul_add_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  gf16_region_mul_add_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (check_errors),
    .pending      (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: switches between always ready, random ready and long stalls
  always @(posedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      <= ready_mode_e'($urandom_range(0, 2));
      ready_mode_left <= $urandom_range(24, 160);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    case (ready_mode)
      ReadyAlways: result_ready <= 1'b1;
      ReadyRandom: result_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          result_ready <= 1'b0;
          stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
          result_ready <= 1'b0;
          stall_left   <= $urandom_range(1, 30);
        end else begin
          result_ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 16'h0001;
      3:       return 16'h8000;
      default: return WordW'($urandom);
    endcase
  endfunction

  function automatic logic [PolyW-1:0] pick_poly();
    case ($urandom_range(0, 9))
      0:       return PolyReset;
      1:       return '1;
      2:       return 17'h10000;
      3:       return {1'b0, WordW'($urandom)};  // bit 16 left clear
      default: return {1'b1, WordW'($urandom)};
    endcase
  endfunction

  function automatic item_t mk_item(
    input logic [WordW-1:0] a,
    input logic [WordW-1:0] b,
    input logic [WordW-1:0] c,
    input logic [WordW-1:0] d,
    input logic             lw
  );
    item_t w;
    w.src_a     = a;
    w.src_b     = b;
    w.src_c     = c;
    w.dst_old   = d;
    w.last_word = lw;
    return w;
  endfunction

  // caller lowers cfg_we once the whole sequence is written
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_setup(
    input logic [PolyW-1:0]  poly,
    input logic [WordW-1:0]  ca,
    input logic [WordW-1:0]  cb,
    input logic [WordW-1:0]  cc,
    input logic [CountW-1:0] cnt,
    input logic              acc,
    input bit                spare
  );
    write_reg(RegPolynomial, poly);
    write_reg(RegCoefA, CfgDataW'(ca));
    write_reg(RegCoefB, CfgDataW'(cb));
    write_reg(RegCoefC, CfgDataW'(cc));
    write_reg(RegSourceCount, CfgDataW'(cnt));
    write_reg(RegAccumulate, CfgDataW'(acc));
    // writes past the last register must leave everything alone
    if (spare) begin
      write_reg(RegSpareLo, CfgDataW'($urandom));
      write_reg(RegSpareHi, '1);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic put_word(input item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    burst_left--;
  endtask

  // first clock lets the checker count the final beat before it is read
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_regions(input int n_words);
    item_t w;
    int    region_left;
    region_left = 0;
    for (int k = 0; k < n_words; k++) begin
      if (region_left == 0) begin
        region_left = $urandom_range(1, 24);
      end
      w = mk_item(pick_word(), pick_word(), pick_word(), pick_word(), region_left == 1);
      // stray flag now and then
      if ($urandom_range(0, 15) == 0) begin
        w.last_word = ~w.last_word;
      end
      region_left--;
      put_word(w);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults straight out of reset
    put_word(mk_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    put_word(mk_item(16'h8000, 16'h0001, 16'haaaa, 16'h5555, 1'b0));
    settle();

    // three sources, accumulate, extreme coefficients
    load_setup(PolyReset, 16'hffff, 16'h0001, 16'h8000, 2'd3, 1'b1, 1'b0);
    put_word(mk_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    put_word(mk_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    put_word(mk_item(16'h0001, 16'h0001, 16'h0001, 16'h0000, 1'b0));
    put_word(mk_item(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1));
    put_word(mk_item(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0));
    put_word(mk_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1));
    put_word(mk_item(16'hffff, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    put_word(mk_item(16'h0000, 16'hffff, 16'h0000, 16'h0000, 1'b0));
    put_word(mk_item(16'h0000, 16'h0000, 16'hffff, 16'h0000, 1'b0));
    put_word(mk_item(16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b1));
    settle();

    // zero source count, polynomial without bit 16, overwrite mode
    load_setup(17'h0002d, 16'h8000, 16'hffff, 16'hffff, 2'd0, 1'b0, 1'b1);
    put_word(mk_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    put_word(mk_item(16'h8000, 16'h1234, 16'h5678, 16'h9abc, 1'b0));
    put_word(mk_item(16'h0001, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    settle();

    // two sources, all-ones polynomial
    load_setup(17'h1ffff, 16'hffff, 16'hffff, 16'h1234, 2'd2, 1'b0, 1'b0);
    put_word(mk_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0));
    put_word(mk_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    put_word(mk_item(16'h0001, 16'h8000, 16'h0000, 16'hffff, 1'b0));
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      load_setup(pick_poly(), pick_word(), pick_word(), pick_word(),
                 CountW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3) == 0);
      run_regions($urandom_range(90, 125));
      settle();
    end

    if (check_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
